// File: rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants of the thermistor linearisation core
// Word layouts, fixed-point widths, coefficient resets and the load table.
// ----------------------------------------------------------------------------
package tcc_pkg;

    // Defaults of the top-level parameters.
    localparam int CHAN_COUNT_DEF = 10;
    localparam int ADC_BITS_DEF   = 12;

    // Field and register widths.
    localparam int CODE_W     = 12;
    localparam int CHAN_W     = 4;
    localparam int TEMP_W     = 15;
    localparam int COEF_W     = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int LOAD_W     = 10;
    localparam int LOAD_TABLE_LEN = 10;

    // Fixed-point widths. Every log operand is below 2^26, so the integer
    // part of a log fits five bits and the derived terms stay within these.
    localparam int K_W        = 5;
    localparam int FRAC_W     = 32;
    localparam int LOG_STEPS  = 32;
    localparam int L_W        = 38;
    localparam int X_W        = 38;
    localparam int X2_W       = 42;
    localparam int X3_W       = 46;
    localparam int BX_W       = 55;
    localparam int CX3_W      = 63;
    localparam int S_W        = 64;
    localparam int LN2_W      = 33;
    localparam int DIV_BITS   = 16;

    localparam logic signed [LN2_W-1:0]  LN2_Q32      = 33'sd2977044472;
    localparam logic        [S_W-1:0]    HUNDRED_Q40  = 64'd109951162777600;
    localparam logic        [DIV_BITS-1:0] KELVIN_CENTI = 16'd27315;
    localparam logic        [TEMP_W-1:0] TEMP_MAX     = 15'd30000;

    localparam logic signed [COEF_W-1:0] COEF_CONST_RST  = 48'sd25556402623;
    localparam logic signed [COEF_W-1:0] COEF_LINEAR_RST = -48'sd3958611201;
    localparam logic signed [COEF_W-1:0] COEF_CUBIC_RST  = 48'sd16614673;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_CONST  = 2'd0,
        CFG_COEF_LINEAR = 2'd1,
        CFG_COEF_CUBIC  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [CODE_W-1:0] adc_code;
        logic [CHAN_W-1:0] channel;
    } in_word_t;

    typedef struct packed {
        logic [TEMP_W-1:0] temperature_centi;
        logic              clamped;
    } out_word_t;

    typedef struct packed {
        logic [K_W-1:0]    k;
        logic [FRAC_W-1:0] m;
    } norm_t;

    // One word of the log chain: two lanes, numerator and denominator.
    typedef struct packed {
        logic [FRAC_W-1:0] m_num;
        logic [FRAC_W-1:0] m_den;
        logic [FRAC_W-1:0] f_num;
        logic [FRAC_W-1:0] f_den;
        logic [K_W-1:0]    k_num;
        logic [K_W-1:0]    k_den;
        logic              clamp;
    } log_t;

    // One word of the divider chain.
    typedef struct packed {
        logic [S_W-1:0]      rem;
        logic [S_W-1:0]      den;
        logic [DIV_BITS-1:0] num_lo;
        logic [DIV_BITS-1:0] quo;
        logic                clamp;
        logic                sat;
    } div_t;

    typedef struct packed {
        logic              clamp;
        logic signed [X_W-1:0] x;
    } side_x_t;

    typedef struct packed {
        logic              clamp;
        logic signed [BX_W-1:0] bx;
    } side_bx_t;

    function automatic logic [LOAD_W-1:0] load_ohms(input logic [CHAN_W-1:0] ch);
        logic [LOAD_W-1:0] r;
        case (ch)
            4'd0:    r = 10'd991;
            4'd1:    r = 10'd994;
            4'd2:    r = 10'd989;
            4'd3:    r = 10'd998;
            4'd4:    r = 10'd996;
            4'd5:    r = 10'd993;
            4'd6:    r = 10'd1002;
            4'd7:    r = 10'd987;
            4'd8:    r = 10'd984;
            4'd9:    r = 10'd996;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Position of the top set bit and the value normalised to Q31.
    function automatic norm_t log_norm(input logic [FRAC_W-1:0] v);
        norm_t n;
        logic [K_W-1:0] k;
        k = '0;
        for (int i = 0; i < FRAC_W; i++) begin
            if (v[i]) begin
                k = K_W'(i);
            end
        end
        n.k = k;
        n.m = v << (K_W'(FRAC_W - 1) - k);
        return n;
    endfunction

endpackage

// File: rtl/thermistor_code_to_celsius_core.sv
// ----------------------------------------------------------------------------
// thermistor_code_to_celsius_core: thermistor reading to hundredths of a degree
// Divider resistance, binary log, Steinhart-Hart polynomial and reciprocal,
// all as one pipeline that takes a word in every clock cycle.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                          Handshake
//  -------   -----------------------------  -------------------------------
//  sample    start, busy, sample            taken when start is high
//                                           and busy is low
//  result    done, result                   one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_index, cfg_data    written when cfg_we is high
//
// A word takes the same path whatever ADC_BITS is: two input stages, 32 log
// cells, one difference stage, four multipliers in series of five stages
// each, a sum stage, a divider set-up stage, 16 divider cells and the
// output register. The 32-cell log chain and the 16-cell divider chain
// make up most of that path.
// A new word may enter in every cycle, so busy is always low.
// Reset clears the stage valid bits and loads the coefficient defaults;
// the data path itself is not reset. The receiver cannot stall the result.
//
// The coefficient registers feed the pipeline directly, so they are to be
// written only when no word is in flight.
// ----------------------------------------------------------------------------
module thermistor_code_to_celsius_core #(
    parameter int CHAN_COUNT = tcc_pkg::CHAN_COUNT_DEF,
    parameter int ADC_BITS   = tcc_pkg::ADC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tcc_pkg::in_word_t             sample,
    output logic                          done,
    output tcc_pkg::out_word_t            result,
    input  logic                          cfg_we,
    input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcc_pkg::COEF_W-1:0]    cfg_data
);

    // Width of the log operands: load resistance times code.
    localparam int V_W = ADC_BITS + tcc_pkg::LOAD_W;
    localparam logic [ADC_BITS-1:0] FULL = {ADC_BITS{1'b1}};

    // ------------------------------------------------------------------
    // Coefficient registers
    // ------------------------------------------------------------------
    logic signed [tcc_pkg::COEF_W-1:0] coef_const_reg;
    logic signed [tcc_pkg::COEF_W-1:0] coef_linear_reg;
    logic signed [tcc_pkg::COEF_W-1:0] coef_cubic_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_const_reg  <= tcc_pkg::COEF_CONST_RST;
            coef_linear_reg <= tcc_pkg::COEF_LINEAR_RST;
            coef_cubic_reg  <= tcc_pkg::COEF_CUBIC_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcc_pkg::CFG_COEF_CONST:  coef_const_reg  <= cfg_data;
                tcc_pkg::CFG_COEF_LINEAR: coef_linear_reg <= cfg_data;
                tcc_pkg::CFG_COEF_CUBIC:  coef_cubic_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 0: resistance numerator and denominator, input checks
    // ------------------------------------------------------------------
    logic [ADC_BITS-1:0]        code;
    logic [tcc_pkg::LOAD_W-1:0] load;
    logic                       clamp_in;

    logic           v0_valid_reg;
    logic           v0_clamp_reg;
    logic [V_W-1:0] v_num_reg;
    logic [V_W-1:0] v_den_reg;

    assign code = ADC_BITS'(sample.adc_code);
    assign load = tcc_pkg::load_ohms(sample.channel);
    // Zero code, full scale and an unknown channel all give a clamped zero.
    assign clamp_in = (code == '0) || (code == FULL)
                   || (int'(sample.channel) >= CHAN_COUNT)
                   || (int'(sample.channel) >= tcc_pkg::LOAD_TABLE_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_valid_reg <= 1'b0;
        end
        else
        begin
            v0_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        v0_clamp_reg <= clamp_in;
        v_num_reg    <= V_W'(load) * V_W'(code);
        v_den_reg    <= V_W'(FULL - code);
    end

    // ------------------------------------------------------------------
    // Stage 1: normalisation of both log operands to Q31
    // ------------------------------------------------------------------
    tcc_pkg::norm_t norm_num;
    tcc_pkg::norm_t norm_den;
    logic           log_in_valid_reg;
    tcc_pkg::log_t  log_in_reg;

    assign norm_num = tcc_pkg::log_norm(tcc_pkg::FRAC_W'(v_num_reg));
    assign norm_den = tcc_pkg::log_norm(tcc_pkg::FRAC_W'(v_den_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_in_valid_reg <= 1'b0;
        end
        else
        begin
            log_in_valid_reg <= v0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        log_in_reg.m_num <= norm_num.m;
        log_in_reg.m_den <= norm_den.m;
        log_in_reg.k_num <= norm_num.k;
        log_in_reg.k_den <= norm_den.k;
        log_in_reg.f_num <= '0;
        log_in_reg.f_den <= '0;
        log_in_reg.clamp <= v0_clamp_reg;
    end

    // ------------------------------------------------------------------
    // Log chain: one fraction bit per cell
    // ------------------------------------------------------------------
    logic          log_valid [tcc_pkg::LOG_STEPS+1];
    tcc_pkg::log_t log_word  [tcc_pkg::LOG_STEPS+1];

    assign log_valid[0] = log_in_valid_reg;
    assign log_word[0]  = log_in_reg;

    for (genvar i = 0; i < tcc_pkg::LOG_STEPS; i++)
    begin : g_log
        tcc_log_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (log_valid[i]),
            .in_word   (log_word[i]),
            .out_valid (log_valid[i+1]),
            .out_word  (log_word[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage 2: log2 of the resistance as a difference of the two logs
    // ------------------------------------------------------------------
    tcc_pkg::log_t log_out;
    logic [tcc_pkg::L_W-1:0] lg_num;
    logic [tcc_pkg::L_W-1:0] lg_den;

    logic                           l_valid_reg;
    logic                           l_clamp_reg;
    logic signed [tcc_pkg::L_W-1:0] l_reg;

    assign log_out = log_word[tcc_pkg::LOG_STEPS];
    assign lg_num  = {{(tcc_pkg::L_W-tcc_pkg::K_W-tcc_pkg::FRAC_W){1'b0}},
                      log_out.k_num, log_out.f_num};
    assign lg_den  = {{(tcc_pkg::L_W-tcc_pkg::K_W-tcc_pkg::FRAC_W){1'b0}},
                      log_out.k_den, log_out.f_den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_valid_reg <= 1'b0;
        end
        else
        begin
            l_valid_reg <= log_valid[tcc_pkg::LOG_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg       <= lg_num - lg_den;
        l_clamp_reg <= log_out.clamp;
    end

    // ------------------------------------------------------------------
    // Polynomial: x = L ln2, x^2, x^3, B x and C x^3
    // ------------------------------------------------------------------
    logic                                m1_valid;
    logic signed [tcc_pkg::L_W+tcc_pkg::LN2_W-32:0] m1_res;
    logic                                m1_clamp;
    logic signed [tcc_pkg::X_W-1:0]      x;
    tcc_pkg::side_x_t                    m2_side_in;

    tcc_mulq #(
        .A_W    (tcc_pkg::L_W),
        .B_W    (tcc_pkg::LN2_W),
        .SIDE_W (1)
    ) u_mul_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (l_valid_reg),
        .a         (l_reg),
        .b         (tcc_pkg::LN2_Q32),
        .in_side   (l_clamp_reg),
        .out_valid (m1_valid),
        .res       (m1_res),
        .out_side  (m1_clamp)
    );

    assign x                = m1_res[tcc_pkg::X_W-1:0];
    assign m2_side_in.clamp = m1_clamp;
    assign m2_side_in.x     = x;

    logic                                m2_valid;
    logic signed [2*tcc_pkg::X_W-32:0]   m2_res;
    tcc_pkg::side_x_t                    m2_side;
    logic signed [tcc_pkg::X2_W-1:0]     x2;

    tcc_mulq #(
        .A_W    (tcc_pkg::X_W),
        .B_W    (tcc_pkg::X_W),
        .SIDE_W ($bits(tcc_pkg::side_x_t))
    ) u_mul_x2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m1_valid),
        .a         (x),
        .b         (x),
        .in_side   (m2_side_in),
        .out_valid (m2_valid),
        .res       (m2_res),
        .out_side  (m2_side)
    );

    assign x2 = m2_res[tcc_pkg::X2_W-1:0];

    // x^3 and B x run side by side with equal latency.
    logic                                        m3_valid;
    logic signed [tcc_pkg::X2_W+tcc_pkg::X_W-32:0] m3_res;
    logic                                        m3_clamp;
    logic signed [tcc_pkg::X3_W-1:0]             x3;

    tcc_mulq #(
        .A_W    (tcc_pkg::X2_W),
        .B_W    (tcc_pkg::X_W),
        .SIDE_W (1)
    ) u_mul_x3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m2_valid),
        .a         (x2),
        .b         (m2_side.x),
        .in_side   (m2_side.clamp),
        .out_valid (m3_valid),
        .res       (m3_res),
        .out_side  (m3_clamp)
    );

    logic                                m3b_valid;
    logic signed [tcc_pkg::BX_W-1:0]     m3b_res;
    logic                                m3b_clamp;

    tcc_mulq #(
        .A_W    (tcc_pkg::COEF_W),
        .B_W    (tcc_pkg::X_W),
        .SIDE_W (1)
    ) u_mul_bx (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m2_valid),
        .a         (coef_linear_reg),
        .b         (m2_side.x),
        .in_side   (m2_side.clamp),
        .out_valid (m3b_valid),
        .res       (m3b_res),
        .out_side  (m3b_clamp)
    );

    assign x3 = m3_res[tcc_pkg::X3_W-1:0];

    tcc_pkg::side_bx_t                   m4_side_in;
    logic                                m4_valid;
    logic signed [tcc_pkg::CX3_W-1:0]    m4_res;
    tcc_pkg::side_bx_t                   m4_side;

    assign m4_side_in.clamp = m3_clamp;
    assign m4_side_in.bx    = m3b_res;

    tcc_mulq #(
        .A_W    (tcc_pkg::COEF_W),
        .B_W    (tcc_pkg::X3_W),
        .SIDE_W ($bits(tcc_pkg::side_bx_t))
    ) u_mul_cx3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m3_valid),
        .a         (coef_cubic_reg),
        .b         (x3),
        .in_side   (m4_side_in),
        .out_valid (m4_valid),
        .res       (m4_res),
        .out_side  (m4_side)
    );

    // ------------------------------------------------------------------
    // Sum stage: s = A + B x + C x^3 in Q40
    // ------------------------------------------------------------------
    logic                           s_valid_reg;
    logic                           s_clamp_reg;
    logic signed [tcc_pkg::S_W-1:0] s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= m4_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg       <= tcc_pkg::S_W'(coef_const_reg) + tcc_pkg::S_W'(m4_side.bx)
                     + tcc_pkg::S_W'(m4_res);
        s_clamp_reg <= m4_side.clamp;
    end

    // ------------------------------------------------------------------
    // Divider set-up: rounded numerator, and saturation when the quotient
    // would not fit sixteen bits
    // ------------------------------------------------------------------
    logic [tcc_pkg::S_W-1:0] numer;
    logic                    s_nonpos;
    logic                    q_big;
    logic                    div_in_valid_reg;
    tcc_pkg::div_t           div_in_reg;

    assign numer    = tcc_pkg::HUNDRED_Q40 + {1'b0, s_reg[tcc_pkg::S_W-1:1]};
    assign s_nonpos = s_reg[tcc_pkg::S_W-1] || (s_reg == '0);
    assign q_big    = {{tcc_pkg::DIV_BITS{1'b0}},
                       numer[tcc_pkg::S_W-1:tcc_pkg::DIV_BITS]} >= s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_in_valid_reg <= 1'b0;
        end
        else
        begin
            div_in_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        div_in_reg.rem    <= {{tcc_pkg::DIV_BITS{1'b0}},
                              numer[tcc_pkg::S_W-1:tcc_pkg::DIV_BITS]};
        div_in_reg.den    <= s_reg;
        div_in_reg.num_lo <= numer[tcc_pkg::DIV_BITS-1:0];
        div_in_reg.quo    <= '0;
        div_in_reg.clamp  <= s_clamp_reg || s_nonpos;
        div_in_reg.sat    <= q_big;
    end

    // ------------------------------------------------------------------
    // Divider chain: one quotient bit per cell
    // ------------------------------------------------------------------
    logic          div_valid [tcc_pkg::DIV_BITS+1];
    tcc_pkg::div_t div_word  [tcc_pkg::DIV_BITS+1];

    assign div_valid[0] = div_in_valid_reg;
    assign div_word[0]  = div_in_reg;

    for (genvar i = 0; i < tcc_pkg::DIV_BITS; i++)
    begin : g_div
        tcc_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[i]),
            .in_word   (div_word[i]),
            .out_valid (div_valid[i+1]),
            .out_word  (div_word[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: Kelvin offset, clamp and saturation
    // ------------------------------------------------------------------
    tcc_pkg::div_t              div_out;
    logic [tcc_pkg::DIV_BITS-1:0] centi;
    tcc_pkg::out_word_t         result_next;
    logic                       done_reg;
    tcc_pkg::out_word_t         result_reg;

    assign div_out = div_word[tcc_pkg::DIV_BITS];
    assign centi   = div_out.quo - tcc_pkg::KELVIN_CENTI;

    always_comb
    begin
        result_next.temperature_centi = '0;
        result_next.clamped           = 1'b1;
        if (div_out.clamp)
        begin
            result_next.clamped = 1'b1;
        end
        else if (div_out.sat)
        begin
            result_next.temperature_centi = tcc_pkg::TEMP_MAX;
            result_next.clamped           = 1'b0;
        end
        else if (div_out.quo <= tcc_pkg::KELVIN_CENTI)
        begin
            // At or below freezing of the scale: forced to zero.
            result_next.clamped = 1'b1;
        end
        else if (centi > {1'b0, tcc_pkg::TEMP_MAX})
        begin
            result_next.temperature_centi = tcc_pkg::TEMP_MAX;
            result_next.clamped           = 1'b0;
        end
        else
        begin
            result_next.temperature_centi = centi[tcc_pkg::TEMP_W-1:0];
            result_next.clamped           = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid[tcc_pkg::DIV_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.clamped) |-> (result.temperature_centi == '0))
        else $error("clamped result carries a nonzero temperature");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.clamped) |->
            ((result.temperature_centi != '0)
             && (result.temperature_centi <= tcc_pkg::TEMP_MAX)))
        else $error("unclamped result outside its range");

    a_lane_align: assert property (@(posedge clk) disable iff (!rst_n)
        (m3_valid == m3b_valid) && (!m3_valid || (m3_clamp == m3b_clamp)))
        else $error("cubic and linear product lanes out of step");

endmodule

// File: rtl/tcc_log_cell.sv
// ----------------------------------------------------------------------------
// tcc_log_cell: one squaring step of the binary logarithm
// Squares both mantissas and shifts one fraction bit into each lane.
// ----------------------------------------------------------------------------
module tcc_log_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  tcc_pkg::log_t in_word,
    output logic          out_valid,
    output tcc_pkg::log_t out_word
);

    logic          valid_reg;
    tcc_pkg::log_t word_reg;
    tcc_pkg::log_t word_next;
    logic [2*tcc_pkg::FRAC_W-1:0] sq_num;
    logic [2*tcc_pkg::FRAC_W-1:0] sq_den;
    logic [tcc_pkg::FRAC_W:0]     t_num;
    logic [tcc_pkg::FRAC_W:0]     t_den;

    always_comb
    begin
        sq_num = {{tcc_pkg::FRAC_W{1'b0}}, in_word.m_num}
               * {{tcc_pkg::FRAC_W{1'b0}}, in_word.m_num};
        sq_den = {{tcc_pkg::FRAC_W{1'b0}}, in_word.m_den}
               * {{tcc_pkg::FRAC_W{1'b0}}, in_word.m_den};
        t_num = sq_num[2*tcc_pkg::FRAC_W-1:tcc_pkg::FRAC_W-1];
        t_den = sq_den[2*tcc_pkg::FRAC_W-1:tcc_pkg::FRAC_W-1];
        word_next       = in_word;
        // A square at or above two renormalises and yields a one bit.
        word_next.m_num = t_num[tcc_pkg::FRAC_W] ? t_num[tcc_pkg::FRAC_W:1]
                                                 : t_num[tcc_pkg::FRAC_W-1:0];
        word_next.m_den = t_den[tcc_pkg::FRAC_W] ? t_den[tcc_pkg::FRAC_W:1]
                                                 : t_den[tcc_pkg::FRAC_W-1:0];
        word_next.f_num = {in_word.f_num[tcc_pkg::FRAC_W-2:0], t_num[tcc_pkg::FRAC_W]};
        word_next.f_den = {in_word.f_den[tcc_pkg::FRAC_W-2:0], t_den[tcc_pkg::FRAC_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// File: rtl/tcc_mulq.sv
// ----------------------------------------------------------------------------
// tcc_mulq: pipelined signed Q32 multiplier
// Sign and magnitude product, one 16-bit slice of b per stage, then >>32.
// ----------------------------------------------------------------------------
module tcc_mulq #(
    parameter int A_W    = 48,
    parameter int B_W    = 38,
    parameter int SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic signed [A_W-1:0]     a,
    input  logic signed [B_W-1:0]     b,
    input  logic [SIDE_W-1:0]         in_side,
    output logic                      out_valid,
    output logic signed [A_W+B_W-32:0] res,
    output logic [SIDE_W-1:0]         out_side
);

    localparam int CH_W  = 16;
    localparam int NSTEP = (B_W + CH_W - 1) / CH_W;
    localparam int BP_W  = NSTEP * CH_W;
    localparam int P_W   = A_W + B_W;
    localparam int R_W   = P_W - 31;

    logic [NSTEP:0]    valid_reg;
    logic [P_W-1:0]    acc_reg   [NSTEP+1];
    logic [A_W-1:0]    mag_a_reg [NSTEP+1];
    logic [BP_W-1:0]   mag_b_reg [NSTEP+1];
    logic              neg_reg   [NSTEP+1];
    logic [SIDE_W-1:0] side_reg  [NSTEP+1];

    logic              out_valid_reg;
    logic [R_W-1:0]    res_reg;
    logic [SIDE_W-1:0] out_side_reg;

    logic [A_W-1:0]    a_mag;
    logic [B_W-1:0]    b_mag;
    logic [R_W-1:0]    r_mag;

    assign a_mag = a[A_W-1] ? A_W'(~a + 1'b1) : A_W'(a);
    assign b_mag = b[B_W-1] ? B_W'(~b + 1'b1) : B_W'(b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg[0]   <= '0;
        mag_a_reg[0] <= a_mag;
        mag_b_reg[0] <= BP_W'(b_mag);
        neg_reg[0]   <= a[A_W-1] ^ b[B_W-1];
        side_reg[0]  <= in_side;
    end

    for (genvar j = 0; j < NSTEP; j++)
    begin : g_step
        logic [A_W+CH_W-1:0] pp;

        assign pp = {{CH_W{1'b0}}, mag_a_reg[j]}
                  * {{A_W{1'b0}}, mag_b_reg[j][CH_W*j +: CH_W]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j+1] <= 1'b0;
            end
            else
            begin
                valid_reg[j+1] <= valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            acc_reg[j+1]   <= acc_reg[j] + (P_W'(pp) << (CH_W * j));
            mag_a_reg[j+1] <= mag_a_reg[j];
            mag_b_reg[j+1] <= mag_b_reg[j];
            neg_reg[j+1]   <= neg_reg[j];
            side_reg[j+1]  <= side_reg[j];
        end
    end

    // Truncation is on the magnitude, so the result rounds toward zero.
    assign r_mag = {1'b0, acc_reg[NSTEP][P_W-1:32]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= valid_reg[NSTEP];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= neg_reg[NSTEP] ? (~r_mag + 1'b1) : r_mag;
        out_side_reg <= side_reg[NSTEP];
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign out_side  = out_side_reg;

endmodule

// File: rtl/tcc_div_cell.sv
// ----------------------------------------------------------------------------
// tcc_div_cell: one quotient bit of the restoring divider
// Shifts in one numerator bit, compares against the divisor, subtracts.
// ----------------------------------------------------------------------------
module tcc_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  tcc_pkg::div_t in_word,
    output logic          out_valid,
    output tcc_pkg::div_t out_word
);

    logic          valid_reg;
    tcc_pkg::div_t word_reg;
    tcc_pkg::div_t word_next;
    logic [tcc_pkg::S_W-1:0] r2;
    logic                    ge;

    always_comb
    begin
        r2 = {in_word.rem[tcc_pkg::S_W-2:0], in_word.num_lo[tcc_pkg::DIV_BITS-1]};
        ge = (r2 >= in_word.den);
        word_next        = in_word;
        word_next.rem    = ge ? (r2 - in_word.den) : r2;
        word_next.num_lo = {in_word.num_lo[tcc_pkg::DIV_BITS-2:0], 1'b0};
        word_next.quo    = {in_word.quo[tcc_pkg::DIV_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of thermistor_code_to_celsius_core
// Converter words are sent through the sample handshake and every result
// word is compared with a fixed-point model of the linearisation, held here.
// ----------------------------------------------------------------------------
module tb;

    // Load resistances of the ten populated channels, in ohms.
    localparam int unsigned LOAD_TABLE [10] = '{991, 994, 989, 998, 996,
                                               993, 1002, 987, 984, 996};
    localparam logic [11:0] FULL_CODE = 12'd4095;
    // Wait after the last expected word, longer than the core's pipeline.
    localparam int DRAIN_CYCLES = 80;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    tcc_pkg::in_word_t             sample;
    logic                          done;
    tcc_pkg::out_word_t            result;
    logic                          cfg_we;
    logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tcc_pkg::COEF_W-1:0]    cfg_data;

    // Coefficients as the core should currently hold them, sign-extended.
    logic signed [63:0] a_coef;
    logic signed [63:0] b_coef;
    logic signed [63:0] c_coef;

    tcc_pkg::out_word_t celsius_due[$];
    int                 mismatches;

    thermistor_code_to_celsius_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Product of two Q32 quantities, truncated towards zero and saturated.
    function automatic logic signed [63:0] q32_product(input logic signed [63:0] a,
                                                       input logic signed [63:0] b);
        logic         negative;
        logic [63:0]  mag_a;
        logic [63:0]  mag_b;
        logic [127:0] wide;
        logic [63:0]  mag;
        negative = a[63] != b[63];
        mag_a = a[63] ? (~a + 64'd1) : a;
        mag_b = b[63] ? (~b + 64'd1) : b;
        wide = {64'd0, mag_a} * {64'd0, mag_b};
        if (wide[127:96] != 0 || wide[95])
            mag = 64'h7FFF_FFFF_FFFF_FFFF;
        else
            mag = wide[95:32];
        return negative ? -$signed(mag) : $signed(mag);
    endfunction

    // Binary logarithm in Q32 by repeated squaring of the normalised mantissa.
    function automatic logic signed [63:0] log2_q32(input logic [63:0] v);
        int          top;
        logic [63:0] mant;
        logic [63:0] frac;
        top = 0;
        frac = '0;
        for (int i = 63; i > 0; i--)
        begin
            if (v[i] && top == 0)
                top = i;
        end
        mant = (top >= 31) ? (v >> (top - 31)) : (v << (31 - top));
        for (int i = 0; i < 32; i++)
        begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= 64'h1_0000_0000)
            begin
                mant = mant >> 1;
                frac[0] = 1'b1;
            end
        end
        return $signed((64'(top) << 32) + frac);
    endfunction

    // Temperature word the core should give for one converter word.
    function automatic tcc_pkg::out_word_t celsius_of(input tcc_pkg::in_word_t w);
        tcc_pkg::out_word_t o;
        logic signed [63:0] lg;
        logic signed [63:0] ln_r;
        logic signed [63:0] ln_sq;
        logic signed [63:0] ln_cube;
        logic signed [63:0] denom;
        logic [63:0]        kelvin;
        logic signed [63:0] centi;
        o.temperature_centi = '0;
        o.clamped = 1'b1;
        // Zero code, full scale and channels without a load resistor clamp.
        if (w.adc_code == 0 || w.adc_code == FULL_CODE || w.channel >= 10)
            return o;
        lg = log2_q32(64'(LOAD_TABLE[w.channel]) * 64'(w.adc_code))
             - log2_q32(64'(FULL_CODE - w.adc_code));
        ln_r = q32_product(lg, 64'sd2977044472);
        ln_sq = q32_product(ln_r, ln_r);
        ln_cube = q32_product(ln_sq, ln_r);
        denom = a_coef + q32_product(b_coef, ln_r) + q32_product(c_coef, ln_cube);
        if (denom <= 0)
            return o;
        kelvin = (64'd109951162777600 + (denom >> 1)) / denom;
        centi = $signed(kelvin) - 64'sd27315;
        if (centi <= 0)
            return o;
        if (centi > 30000)
            centi = 30000;
        o.temperature_centi = centi[tcc_pkg::TEMP_W-1:0];
        o.clamped = 1'b0;
        return o;
    endfunction

    // Every result word is taken at the edge that ends its strobe cycle.
    always @(posedge clk)
    begin
        tcc_pkg::out_word_t want;
        if (rst_n && done)
        begin
            if (celsius_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: temp %0d clamp %0b",
                             result.temperature_centi, result.clamped);
            end
            else
            begin
                want = celsius_due.pop_front();
                if (result.temperature_centi !== want.temperature_centi ||
                    result.clamped !== want.clamped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: temp %0d clamp %0b, expected temp %0d clamp %0b",
                                 result.temperature_centi, result.clamped,
                                 want.temperature_centi, want.clamped);
                end
            end
        end
    end

    // Sends one word; start is left high so that words can follow back to back.
    task automatic send_word(input logic [11:0] code, input logic [3:0] chan);
        tcc_pkg::in_word_t w;
        w.adc_code = code;
        w.channel = chan;
        @(negedge clk);
        start <= 1'b1;
        sample <= w;
        do
            @(posedge clk);
        while (busy);
        celsius_due.push_back(celsius_of(w));
    endtask

    task automatic pause_sender();
        @(negedge clk);
        start <= 1'b0;
        sample <= tcc_pkg::in_word_t'($urandom);
    endtask

    // Waits until every expected word has come and the pipeline is empty.
    task automatic drain_pipeline();
        pause_sender();
        while (celsius_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_coef(input tcc_pkg::cfg_index_t idx,
                              input logic [tcc_pkg::COEF_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            tcc_pkg::CFG_COEF_CONST:  a_coef = {{16{value[tcc_pkg::COEF_W-1]}}, value};
            tcc_pkg::CFG_COEF_LINEAR: b_coef = {{16{value[tcc_pkg::COEF_W-1]}}, value};
            tcc_pkg::CFG_COEF_CUBIC:  c_coef = {{16{value[tcc_pkg::COEF_W-1]}}, value};
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_coefs(input logic [tcc_pkg::COEF_W-1:0] a,
                              input logic [tcc_pkg::COEF_W-1:0] b,
                              input logic [tcc_pkg::COEF_W-1:0] c);
        drain_pipeline();
        write_coef(tcc_pkg::CFG_COEF_CONST, a);
        write_coef(tcc_pkg::CFG_COEF_LINEAR, b);
        write_coef(tcc_pkg::CFG_COEF_CUBIC, c);
    endtask

    // Field extremes, every channel including the unpopulated ones.
    task automatic test_field_extremes();
        send_word(12'd0, 4'd0);
        send_word(FULL_CODE, 4'd9);
        send_word(12'd1, 4'd0);
        send_word(12'd4094, 4'd1);
        send_word(12'd2048, 4'd2);
        for (int ch = 0; ch < 16; ch++)
            send_word(12'(100 + 250 * ch), 4'(ch));
        send_word(12'd1, 4'd15);
        pause_sender();
    endtask

    // Coefficient extremes: denominators at or below zero, tiny and huge.
    task automatic test_coef_extremes();
        load_coefs(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
        send_word(12'd1, 4'd0);
        send_word(12'd2000, 4'd3);
        send_word(12'd4094, 4'd6);
        load_coefs(48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000);
        send_word(12'd1, 4'd0);
        send_word(12'd4094, 4'd4);
        // A one-count denominator saturates at the top of the range.
        load_coefs(48'd1, 48'd0, 48'd0);
        send_word(12'd1000, 4'd5);
        load_coefs(48'd0, 48'd0, 48'd0);
        send_word(12'd1000, 4'd7);
        load_coefs(tcc_pkg::COEF_CONST_RST, tcc_pkg::COEF_LINEAR_RST,
                   tcc_pkg::COEF_CUBIC_RST);
    endtask

    // Random words; each cycle the sender is idle with the given percentage.
    task automatic test_random_words(input int count, input int idle_share);
        logic [11:0] code;
        logic [3:0]  chan;
        for (int n = 0; n < count; n++)
        begin
            if (idle_share > 0 && $urandom_range(99, 0) < idle_share)
            begin
                pause_sender();
                while ($urandom_range(99, 0) < idle_share)
                    @(negedge clk);
            end
            code = 12'($urandom_range(4094, 1));
            chan = 4'($urandom_range(9, 0));
            case ($urandom_range(19, 0))
                0: code = 12'd0;
                1: code = FULL_CODE;
                2: chan = 4'($urandom_range(15, 10));
                3: code = 12'($urandom_range(40, 1));
                4: code = 12'($urandom_range(4094, 4050));
                default: ;
            endcase
            send_word(code, chan);
        end
        pause_sender();
    endtask

    // Coefficients near the defaults keep most words in the useful range.
    task automatic load_near_default_coefs();
        load_coefs(tcc_pkg::COEF_CONST_RST
                       + 48'($signed($urandom_range(2000000000, 0)) - 1000000000),
                   tcc_pkg::COEF_LINEAR_RST
                       + 48'($signed($urandom_range(200000000, 0)) - 100000000),
                   tcc_pkg::COEF_CUBIC_RST
                       + 48'($signed($urandom_range(2000000, 0)) - 1000000));
    endtask

    initial
    begin
        mismatches = 0;
        rst_n = 1'b0;
        start = 1'b0;
        sample = '0;
        cfg_we = 1'b0;
        cfg_index = tcc_pkg::CFG_COEF_CONST;
        cfg_data = '0;
        a_coef = tcc_pkg::COEF_CONST_RST;
        b_coef = tcc_pkg::COEF_LINEAR_RST;
        c_coef = tcc_pkg::COEF_CUBIC_RST;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_field_extremes();
        test_coef_extremes();
        test_random_words(130, 0);
        load_near_default_coefs();
        test_random_words(130, 50);
        load_near_default_coefs();
        test_random_words(120, 0);
        load_coefs(tcc_pkg::COEF_CONST_RST, tcc_pkg::COEF_LINEAR_RST,
                   tcc_pkg::COEF_CUBIC_RST);
        test_random_words(120, 35);

        drain_pipeline();
        if (mismatches == 0 && celsius_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
